### rtl/core/kts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants of the keyword tokenizer scanner
// Token kinds, scanner modes, the token record and character classes.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int DEF_KEYWORD_CHARS = 8;
  localparam int DEF_OFFSET_WIDTH  = 24;
  localparam int DEF_COUNT_WIDTH   = 16;

  // Token kinds
  localparam logic [5:0] K_SUPPLY  = 6'd14;
  localparam logic [5:0] K_INTEGER = 6'd15;
  localparam logic [5:0] K_DOUBLE  = 6'd16;
  localparam logic [5:0] K_STRING  = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd20;
  localparam logic [5:0] K_PLUS    = 6'd21;
  localparam logic [5:0] K_MINUS   = 6'd22;
  localparam logic [5:0] K_STAR    = 6'd23;
  localparam logic [5:0] K_SLASH   = 6'd24;
  localparam logic [5:0] K_PERCENT = 6'd25;
  localparam logic [5:0] K_EQ      = 6'd26;
  localparam logic [5:0] K_NE      = 6'd27;
  localparam logic [5:0] K_LT      = 6'd28;
  localparam logic [5:0] K_GT      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_GE      = 6'd31;
  localparam logic [5:0] K_AND     = 6'd32;
  localparam logic [5:0] K_OR      = 6'd33;
  localparam logic [5:0] K_NOT     = 6'd34;
  localparam logic [5:0] K_ASSIGN  = 6'd35;
  localparam logic [5:0] K_LPAREN  = 6'd36;
  localparam logic [5:0] K_RPAREN  = 6'd37;
  localparam logic [5:0] K_LBRACE  = 6'd38;
  localparam logic [5:0] K_RBRACE  = 6'd39;
  localparam logic [5:0] K_SEMI    = 6'd40;
  localparam logic [5:0] K_COMMA   = 6'd41;
  localparam logic [5:0] K_EOF     = 6'd43;
  localparam logic [5:0] K_ERROR   = 6'd44;
  localparam logic [5:0] K_NONE    = 6'd63;

  // Error codes
  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_UNTERM_STR = 2'd1;
  localparam logic [1:0] E_BAD_DIR    = 2'd2;
  localparam logic [1:0] E_BAD_CHAR   = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_DECIMAL, M_STRING, M_HASH,
    M_DIRECTIVE, M_COMMENT, M_OP
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic [15:0] line;
    logic [15:0] col;
    logic [23:0] off;
    logic [15:0] len;
  } tok_t;

  // Up to three tokens come out of one input word.
  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } rec_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c == "\t") || (c == "\r") || (c == "\n");
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "%": k = K_PERCENT;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // The word buffer shifts bytes in at the bottom, so the last l bytes
  // read like a right-justified string literal.
  function automatic logic [5:0] kw_kind(logic [63:0] w, logic [3:0] l);
    logic [5:0] k;
    k = K_IDENT;
    case (l)
      4'd4: begin
        if (w[31:0] == "ammo") k = 6'd3;
        else if (w[31:0] == "true") k = 6'd18;
      end
      4'd5: begin
        if (w[39:0] == "troop") k = 6'd2;
        else if (w[39:0] == "brief") k = 6'd6;
        else if (w[39:0] == "intel") k = 6'd7;
        else if (w[39:0] == "abort") k = 6'd13;
        else if (w[39:0] == "false") k = 6'd19;
      end
      4'd6: begin
        if (w[47:0] == "tactic") k = 6'd1;
        else if (w[47:0] == "status") k = 6'd5;
        else if (w[47:0] == "adjust") k = 6'd9;
        else if (w[47:0] == "deploy") k = 6'd11;
      end
      4'd7: begin
        if (w[55:0] == "retreat") k = 6'd12;
      end
      4'd8: begin
        if (w == "campaign") k = 6'd0;
        else if (w == "codename") k = 6'd4;
        else if (w == "evaluate") k = 6'd8;
        else if (w == "maintain") k = 6'd10;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/core/kts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_in_if: source byte channel
// Valid/ready channel carrying one source byte or an end-of-source mark.
// ----------------------------------------------------------------------------
interface kts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, char_byte, end_of_source, input ready);
  modport sink (input valid, char_byte, end_of_source, output ready);
endinterface

### rtl/core/kts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_out_if: token channel
// Valid/ready channel carrying one token with its position and length.
// ----------------------------------------------------------------------------
interface kts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [7:0]  offending_char;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, error_kind, offending_char, start_line,
                  start_column, start_offset, token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, offending_char, start_line,
                start_column, start_offset, token_length, last_of_run, output ready);
endinterface

### rtl/core/kts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_front: scanner front end
// Takes one byte per cycle while the queue has room, runs the lexer state
// machine and the position counters; the tokens a byte closes form one record.
// ----------------------------------------------------------------------------
module kts_front
  import kts_pkg::*;
#(
  parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS,
  parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  kts_in_if.sink  char_in,
  input  logic    q_full,
  output logic    push,
  output rec_t    push_rec
);

  localparam int KC = KEYWORD_CHARS;
  localparam int OW = OFFSET_WIDTH;
  localparam int CW = COUNT_WIDTH;
  localparam int WB = 8 * KEYWORD_CHARS;

  mode_t           mode, mode_next;
  logic [7:0]      held, held_next;
  logic [WB-1:0]   wbuf, wbuf_next;
  logic            too_long, too_long_next;
  logic [CW-1:0]   tok_line, tok_line_next;
  logic [CW-1:0]   tok_col, tok_col_next;
  logic [OW-1:0]   tok_off, tok_off_next;
  logic [CW-1:0]   tok_len, tok_len_next;
  logic [CW-1:0]   line_cnt, line_cnt_next;
  logic [CW-1:0]   col_cnt, col_cnt_next;
  logic [OW-1:0]   byte_off, byte_off_next;
  rec_t            rec;
  logic            accept;

  function automatic tok_t mk_tok(logic [5:0] k, logic [1:0] e, logic [7:0] b,
                                  logic [CW-1:0] l, logic [CW-1:0] c,
                                  logic [OW-1:0] o, logic [CW-1:0] n);
    tok_t t;
    t.kind = k;
    t.err  = e;
    t.bad  = b;
    t.line = 16'(l);
    t.col  = 16'(c);
    t.off  = 24'(o);
    t.len  = 16'(n);
    return t;
  endfunction

  function automatic logic [5:0] id_kind(logic [63:0] w, logic t, logic [CW-1:0] n);
    if (t || (n > CW'(8))) return K_IDENT;
    return kw_kind(w, n[3:0]);
  endfunction

  assign char_in.ready = !q_full;
  assign accept        = char_in.valid && char_in.ready;
  assign push          = accept && (rec.cnt != 2'd0);
  assign push_rec      = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      held     <= '0;
      wbuf     <= '0;
      too_long <= 1'b0;
      tok_line <= CW'(1);
      tok_col  <= '0;
      tok_off  <= '0;
      tok_len  <= '0;
      line_cnt <= CW'(1);
      col_cnt  <= '0;
      byte_off <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      held     <= held_next;
      wbuf     <= wbuf_next;
      too_long <= too_long_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_off  <= tok_off_next;
      tok_len  <= tok_len_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
      byte_off <= byte_off_next;
    end
  end

  always_comb begin
    logic [7:0]    c;
    logic          do_idle;
    logic [1:0]    n;
    logic [5:0]    pk;
    logic [CW-1:0] dcol;
    logic [OW-1:0] doff;
    c             = char_in.char_byte;
    do_idle       = 1'b0;
    n             = '0;
    rec           = '0;
    mode_next     = mode;
    held_next     = held;
    wbuf_next     = wbuf;
    too_long_next = too_long;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    tok_len_next  = tok_len;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    byte_off_next = byte_off;
    pk            = punct_kind(c);
    dcol          = (col_cnt != '0) ? col_cnt - CW'(1) : col_cnt;
    doff          = (byte_off != '0) ? byte_off - OW'(1) : byte_off;

    if (char_in.end_of_source) begin
      // Close whatever token is open, then report the end.
      case (mode)
        M_IDENT: begin
          rec.tok[n] = mk_tok(id_kind(wbuf[63:0], too_long, tok_len), E_NONE, 8'd0,
                              tok_line, tok_col, tok_off, tok_len);
          n = n + 2'd1;
        end
        M_NUMBER: begin
          rec.tok[n] = mk_tok(K_INTEGER, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
          n = n + 2'd1;
        end
        M_NUMDOT: begin
          rec.tok[n] = mk_tok(K_INTEGER, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                              (tok_len != '0) ? tok_len - CW'(1) : tok_len);
          n = n + 2'd1;
          rec.tok[n] = mk_tok(K_ERROR, E_BAD_CHAR, ".", line_cnt, dcol, doff, CW'(1));
          n = n + 2'd1;
        end
        M_DECIMAL: begin
          rec.tok[n] = mk_tok(K_DOUBLE, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
          n = n + 2'd1;
        end
        M_STRING: begin
          rec.tok[n] = mk_tok(K_ERROR, E_UNTERM_STR, 8'd0, tok_line, tok_col, tok_off,
                              tok_len);
          n = n + 2'd1;
        end
        M_DIRECTIVE: begin
          if (!too_long && (tok_len == CW'(7)) && (wbuf[47:0] == "supply"))
            rec.tok[n] = mk_tok(K_SUPPLY, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
          else
            rec.tok[n] = mk_tok(K_ERROR, E_BAD_DIR, 8'd0, tok_line, tok_col, tok_off,
                                tok_len);
          n = n + 2'd1;
        end
        M_OP: begin
          case (held)
            "=": rec.tok[n] = mk_tok(K_ASSIGN, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                     tok_len);
            "!": rec.tok[n] = mk_tok(K_NOT, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                     tok_len);
            "<": rec.tok[n] = mk_tok(K_LT, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
            ">": rec.tok[n] = mk_tok(K_GT, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
            default: rec.tok[n] = mk_tok(K_ERROR, E_BAD_CHAR, held, tok_line, tok_col,
                                         tok_off, tok_len);
          endcase
          n = n + 2'd1;
        end
        default: ;
      endcase
      rec.tok[n] = mk_tok(K_EOF, E_NONE, 8'd0, line_cnt, col_cnt, byte_off, '0);
      n = n + 2'd1;
      // Everything returns to its reset value for the next source.
      mode_next     = M_IDLE;
      held_next     = '0;
      wbuf_next     = '0;
      too_long_next = 1'b0;
      tok_line_next = CW'(1);
      tok_col_next  = '0;
      tok_off_next  = '0;
      tok_len_next  = '0;
      line_cnt_next = CW'(1);
      col_cnt_next  = '0;
      byte_off_next = '0;
    end else begin
      case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == "_")) begin
            if (tok_len < CW'(KC)) wbuf_next = {wbuf[WB-9:0], c};
            else too_long_next = 1'b1;
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
          end else begin
            rec.tok[n] = mk_tok(id_kind(wbuf[63:0], too_long, tok_len), E_NONE, 8'd0,
                                tok_line, tok_col, tok_off, tok_len);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
          end else if (c == ".") begin
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
            mode_next = M_NUMDOT;
          end else begin
            rec.tok[n] = mk_tok(K_INTEGER, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) begin
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
            mode_next = M_DECIMAL;
          end else begin
            // The dot was not part of a number: integer, then a stray dot.
            tok_len_next = (tok_len != '0) ? tok_len - CW'(1) : tok_len;
            rec.tok[n] = mk_tok(K_INTEGER, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                tok_len_next);
            n = n + 2'd1;
            rec.tok[n] = mk_tok(K_ERROR, E_BAD_CHAR, ".", line_cnt, dcol, doff, CW'(1));
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_DECIMAL: begin
          if (is_digit(c)) begin
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
          end else begin
            rec.tok[n] = mk_tok(K_DOUBLE, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (tok_len != '1) tok_len_next = tok_len + CW'(1);
          if (c == "\"") begin
            rec.tok[n] = mk_tok(K_STRING, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                tok_len_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_HASH: begin
          if (is_alpha(c)) begin
            wbuf_next = {wbuf[WB-9:0], c};
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
            mode_next = M_DIRECTIVE;
          end else if (c == "\n") begin
            do_idle = 1'b1;
          end else begin
            mode_next = M_COMMENT;
          end
        end
        M_DIRECTIVE: begin
          if (is_alpha(c)) begin
            if (tok_len <= CW'(KC)) wbuf_next = {wbuf[WB-9:0], c};
            else too_long_next = 1'b1;
            if (tok_len != '1) tok_len_next = tok_len + CW'(1);
          end else begin
            if (!too_long && (tok_len == CW'(7)) && (wbuf[47:0] == "supply"))
              rec.tok[n] = mk_tok(K_SUPPLY, E_NONE, 8'd0, tok_line, tok_col, tok_off, tok_len);
            else
              rec.tok[n] = mk_tok(K_ERROR, E_BAD_DIR, 8'd0, tok_line, tok_col, tok_off,
                                  tok_len);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == "\n") do_idle = 1'b1;
        end
        M_OP: begin
          if ((c == "=") && ((held == "=") || (held == "!") || (held == "<") ||
                             (held == ">"))) begin
            tok_len_next = (tok_len != '1) ? tok_len + CW'(1) : tok_len;
            rec.tok[n] = mk_tok((held == "=") ? K_EQ : (held == "!") ? K_NE :
                                (held == "<") ? K_LE : K_GE, E_NONE, 8'd0,
                                tok_line, tok_col, tok_off, tok_len_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (((c == "&") || (c == "|")) && (c == held)) begin
            tok_len_next = (tok_len != '1) ? tok_len + CW'(1) : tok_len;
            rec.tok[n] = mk_tok((c == "&") ? K_AND : K_OR, E_NONE, 8'd0,
                                tok_line, tok_col, tok_off, tok_len_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            case (held)
              "=": rec.tok[n] = mk_tok(K_ASSIGN, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                       tok_len);
              "!": rec.tok[n] = mk_tok(K_NOT, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                       tok_len);
              "<": rec.tok[n] = mk_tok(K_LT, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                       tok_len);
              ">": rec.tok[n] = mk_tok(K_GT, E_NONE, 8'd0, tok_line, tok_col, tok_off,
                                       tok_len);
              default: rec.tok[n] = mk_tok(K_ERROR, E_BAD_CHAR, held, tok_line, tok_col,
                                           tok_off, tok_len);
            endcase
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // The byte that closed a token, or any byte between tokens, may open one.
      if (do_idle) begin
        mode_next = M_IDLE;
        if (!is_space(c)) begin
          tok_line_next = line_cnt;
          tok_col_next  = col_cnt;
          tok_off_next  = byte_off;
          tok_len_next  = CW'(1);
          too_long_next = 1'b0;
          wbuf_next     = '0;
          if (pk != K_NONE) begin
            rec.tok[n] = mk_tok(pk, E_NONE, 8'd0, line_cnt, col_cnt, byte_off, CW'(1));
            n = n + 2'd1;
          end else if ((c == "=") || (c == "!") || (c == "<") || (c == ">") ||
                       (c == "&") || (c == "|")) begin
            held_next = c;
            mode_next = M_OP;
          end else if (c == "#") begin
            mode_next = M_HASH;
          end else if (c == "\"") begin
            mode_next = M_STRING;
          end else if (is_digit(c)) begin
            mode_next = M_NUMBER;
          end else if (is_alpha(c) || (c == "_")) begin
            wbuf_next = {{(WB-8){1'b0}}, c};
            mode_next = M_IDENT;
          end else begin
            rec.tok[n] = mk_tok(K_ERROR, E_BAD_CHAR, c, line_cnt, col_cnt, byte_off, CW'(1));
            n = n + 2'd1;
          end
        end
      end

      if (byte_off != '1) byte_off_next = byte_off + OW'(1);
      if (c == "\n") begin
        if (line_cnt != '1) line_cnt_next = line_cnt + CW'(1);
        col_cnt_next = '0;
      end else if (col_cnt != '1) begin
        col_cnt_next = col_cnt + CW'(1);
      end
    end
    rec.cnt = n;
  end

endmodule

### rtl/core/kts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_queue: two-entry record queue
// Decouples the scanner front end from the token emitter.
// ----------------------------------------------------------------------------
module kts_queue
  import kts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wdata,
  output logic full,
  output logic rvalid,
  output rec_t rdata,
  input  logic pop
);

  rec_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign rvalid = (count != 2'd0);
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/core/kts_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_emit: token emitter
// Holds a record, sends its tokens one per cycle while ready, marks the last.
// ----------------------------------------------------------------------------
module kts_emit
  import kts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  rec_t        q_rec,
  output logic        pop,
  kts_out_if.source   token_out
);

  rec_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       is_last;
  logic       load;
  tok_t       t;

  assign is_last = (idx == cur.cnt - 2'd1);
  assign load    = !cur_valid || (token_out.ready && is_last);
  assign pop     = load && q_valid;
  assign t       = cur.tok[idx];

  assign token_out.valid          = cur_valid;
  assign token_out.token_kind     = t.kind;
  assign token_out.error_kind     = t.err;
  assign token_out.offending_char = t.bad;
  assign token_out.start_line     = t.line;
  assign token_out.start_column   = t.col;
  assign token_out.start_offset   = t.off;
  assign token_out.token_length   = t.len;
  assign token_out.last_of_run    = is_last;

  always_ff @(posedge clk) begin
    if (pop) cur <= q_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= q_valid;
      idx       <= 2'd0;
    end else if (token_out.ready) begin
      idx <= idx + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < cur.cnt))
    else $error("token index beyond record");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != 2'd0))
    else $error("empty record held");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && token_out.ready && !is_last) |=>
      (cur_valid && (idx == $past(idx) + 2'd1)))
    else $error("token index did not advance");

endmodule

### rtl/core/keyword_tokenizer_scanner.sv
`timescale 1ns / 1ps
// A token passes through the two-record queue and the emitter's register.
// The input takes one byte per cycle while the queue has room; a byte that
// closes two or three tokens keeps the emitter busy with each in turn.
// The emitter sends one token per cycle while ready; the queue absorbs bursts.
// Reset (rst, synchronous) returns the scanner to line 1, column 0, offset 0.
// ----------------------------------------------------------------------------
// keyword_tokenizer_scanner: streaming lexer top level
// Front end scans bytes into token records, a queue buffers them and the
// emitter sends the tokens one word at a time.
// ----------------------------------------------------------------------------
module keyword_tokenizer_scanner
  import kts_pkg::*;
#(
  parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS,
  parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  kts_in_if.sink    char_in,
  kts_out_if.source token_out
);

  logic q_full;
  logic push;
  rec_t push_rec;
  logic q_valid;
  rec_t q_rec;
  logic pop;

  kts_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .q_full  (q_full),
    .push    (push),
    .push_rec(push_rec)
  );

  kts_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_rec),
    .full  (q_full),
    .rvalid(q_valid),
    .rdata (q_rec),
    .pop   (pop)
  );

  kts_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rec    (q_rec),
    .pop      (pop),
    .token_out(token_out)
  );

endmodule

### sim/tb_kts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kts_if: testbench-side package
// Defines the expected token record type used by the scoreboard.
// ----------------------------------------------------------------------------
package tb_kts_pkg;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic [15:0] line;
    logic [15:0] col;
    logic [23:0] off;
    logic [15:0] len;
    logic        last;
  } exp_tok_t;

endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyword tokenizer scanner testbench
// Feeds source bytes and end marks, predicts the token stream in a behavioral
// lexer and compares every token word against it, mostly under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import kts_pkg::*;
  import tb_kts_pkg::*;

  localparam int KW_CHARS = 8;
  localparam logic [15:0] CNT_SAT = 16'hFFFF;
  localparam logic [23:0] OFF_SAT = 24'hFFFFFF;

  class token_scoreboard;
    exp_tok_t pending[$];
    int mismatches;
    int checked;

    function new();
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_token(exp_tok_t t);
      pending.insert(pending.size(), t);
    endfunction

    function void check_token(exp_tok_t got);
      exp_tok_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token kind %0d at offset %0d",
                                       got.kind, got.off);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token mismatch: exp k%0d e%0d b%0d l%0d c%0d o%0d n%0d last%0d",
                   want.kind, want.err, want.bad, want.line, want.col, want.off,
                   want.len, want.last,
                   "\n                got k%0d e%0d b%0d l%0d c%0d o%0d n%0d last%0d",
                   got.kind, got.err, got.bad, got.line, got.col, got.off,
                   got.len, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  kts_in_if char_in ();
  kts_out_if token_out ();

  keyword_tokenizer_scanner dut (
    .clk(clk), .rst(rst), .char_in(char_in.sink), .token_out(token_out.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[keyword_tokenizer_scanner] ERROR");
    $finish;
  end

  // Lexer state of the predictor.
  mode_t       lx_mode;
  logic [7:0]  lx_held;
  logic [7:0]  lx_word[KW_CHARS];
  logic        lx_long;
  logic [23:0] lx_toff;
  logic [15:0] lx_tline, lx_tcol, lx_tlen;
  logic [15:0] lx_line, lx_col;
  logic [23:0] lx_off;
  exp_tok_t    step_toks[$];

  token_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  int items_sent, eof_count;

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit word_is(string s);
    if (lx_long || lx_tlen != s.len()) return 0;
    for (int i = 0; i < s.len(); i++) if (lx_word[i] != s[i]) return 0;
    return 1;
  endfunction

  task automatic lexer_reset();
    lx_mode = M_IDLE;
    lx_held = 0;
    foreach (lx_word[i]) lx_word[i] = 0;
    lx_long = 0;
    lx_toff = 0; lx_tline = 1; lx_tcol = 0; lx_tlen = 0;
    lx_line = 1; lx_col = 0; lx_off = 0;
  endtask

  task automatic put_tok(logic [5:0] k, logic [1:0] e, logic [7:0] b,
                         logic [15:0] ln, logic [15:0] cl, logic [23:0] of,
                         logic [15:0] n);
    exp_tok_t t;
    t.kind = k; t.err = e; t.bad = b; t.line = ln; t.col = cl; t.off = of;
    t.len = n; t.last = 0;
    step_toks.insert(step_toks.size(), t);
  endtask

  task automatic put_cur(logic [5:0] k, logic [1:0] e, logic [7:0] b);
    put_tok(k, e, b, lx_tline, lx_tcol, lx_toff, lx_tlen);
  endtask

  task automatic open_token();
    lx_tline = lx_line; lx_tcol = lx_col; lx_toff = lx_off; lx_tlen = 1;
    lx_long = 0;
    foreach (lx_word[i]) lx_word[i] = 0;
  endtask

  task automatic grow();
    if (lx_tlen != CNT_SAT) lx_tlen++;
  endtask

  task automatic store_char(logic [7:0] c, int idx);
    if (idx < KW_CHARS) lx_word[idx] = c;
    else lx_long = 1;
  endtask

  function automatic logic [5:0] word_kind();
    string names[16] = '{"campaign", "tactic", "troop", "ammo", "codename",
      "status", "brief", "intel", "evaluate", "adjust", "maintain", "deploy",
      "retreat", "abort", "true", "false"};
    logic [5:0] kinds[16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
                              18, 19};
    for (int i = 0; i < 16; i++) if (word_is(names[i])) return kinds[i];
    return K_IDENT;
  endfunction

  task automatic close_directive();
    if (!lx_long && lx_tlen == 7 && lx_word[0] == "s" && lx_word[1] == "u" &&
        lx_word[2] == "p" && lx_word[3] == "p" && lx_word[4] == "l" &&
        lx_word[5] == "y") put_cur(K_SUPPLY, E_NONE, 0);
    else put_cur(K_ERROR, E_BAD_DIR, 0);
  endtask

  task automatic close_single_op();
    case (lx_held)
      "=": put_cur(K_ASSIGN, E_NONE, 0);
      "!": put_cur(K_NOT, E_NONE, 0);
      "<": put_cur(K_LT, E_NONE, 0);
      ">": put_cur(K_GT, E_NONE, 0);
      default: put_cur(K_ERROR, E_BAD_CHAR, lx_held);
    endcase
  endtask

  // A dot after digits with no digit behind it ends the integer before the
  // dot and reports the dot itself as a stray character.
  task automatic close_int_dot();
    logic [15:0] cl;
    logic [23:0] of;
    cl = (lx_col != 16'd0) ? lx_col - 16'd1 : 16'd0;
    of = (lx_off != 24'd0) ? lx_off - 24'd1 : 24'd0;
    if (lx_tlen != 16'd0) lx_tlen--;
    put_cur(K_INTEGER, E_NONE, 0);
    put_tok(K_ERROR, E_BAD_CHAR, ".", lx_line, cl, of, 16'd1);
  endtask

  task automatic scan_fresh(logic [7:0] c);
    logic [5:0] k;
    lx_mode = M_IDLE;
    if (c == " " || c == "\t" || c == "\r" || c == "\n") return;
    open_token();
    k = K_NONE;
    case (c)
      "(": k = K_LPAREN;  ")": k = K_RPAREN;
      "{": k = K_LBRACE;  "}": k = K_RBRACE;
      ";": k = K_SEMI;    ",": k = K_COMMA;
      "+": k = K_PLUS;    "-": k = K_MINUS;
      "*": k = K_STAR;    "/": k = K_SLASH;
      "%": k = K_PERCENT;
      "=", "!", "<", ">", "&", "|": begin
        lx_held = c;
        lx_mode = M_OP;
        return;
      end
      "#": begin
        lx_mode = M_HASH;
        return;
      end
      "\"": begin
        lx_mode = M_STRING;
        return;
      end
      default: begin
        if (dig(c)) begin
          lx_mode = M_NUMBER;
          return;
        end
        if (alp(c) || c == "_") begin
          store_char(c, 0);
          lx_mode = M_IDENT;
          return;
        end
        put_cur(K_ERROR, E_BAD_CHAR, c);
        return;
      end
    endcase
    put_cur(k, E_NONE, 0);
  endtask

  task automatic scan_byte(logic [7:0] c);
    case (lx_mode)
      M_IDENT: begin
        if (alp(c) || dig(c) || c == "_") begin
          store_char(c, lx_tlen);
          grow();
          return;
        end
        put_cur(word_kind(), E_NONE, 0);
      end
      M_NUMBER: begin
        if (dig(c)) begin
          grow();
          return;
        end
        if (c == ".") begin
          grow();
          lx_mode = M_NUMDOT;
          return;
        end
        put_cur(K_INTEGER, E_NONE, 0);
      end
      M_NUMDOT: begin
        if (dig(c)) begin
          grow();
          lx_mode = M_DECIMAL;
          return;
        end
        close_int_dot();
      end
      M_DECIMAL: begin
        if (dig(c)) begin
          grow();
          return;
        end
        put_cur(K_DOUBLE, E_NONE, 0);
      end
      M_STRING: begin
        grow();
        if (c == "\"") begin
          put_cur(K_STRING, E_NONE, 0);
          lx_mode = M_IDLE;
        end
        return;
      end
      M_HASH: begin
        if (alp(c)) begin
          store_char(c, 0);
          grow();
          lx_mode = M_DIRECTIVE;
          return;
        end
        if (c != "\n") begin
          lx_mode = M_COMMENT;
          return;
        end
      end
      M_DIRECTIVE: begin
        if (alp(c)) begin
          store_char(c, lx_tlen - 1);
          grow();
          return;
        end
        close_directive();
      end
      M_COMMENT: begin
        if (c != "\n") return;
      end
      M_OP: begin
        if (c == "=" && (lx_held == "=" || lx_held == "!" || lx_held == "<" ||
                         lx_held == ">")) begin
          grow();
          put_cur(lx_held == "=" ? K_EQ : lx_held == "!" ? K_NE :
                  lx_held == "<" ? K_LE : K_GE, E_NONE, 0);
          lx_mode = M_IDLE;
          return;
        end
        if ((c == "&" || c == "|") && c == lx_held) begin
          grow();
          put_cur(c == "&" ? K_AND : K_OR, E_NONE, 0);
          lx_mode = M_IDLE;
          return;
        end
        close_single_op();
      end
      default: ;
    endcase
    scan_fresh(c);
  endtask

  task automatic predict_word(logic [7:0] c, logic eos);
    step_toks.delete();
    if (eos) begin
      case (lx_mode)
        M_IDENT: put_cur(word_kind(), E_NONE, 0);
        M_NUMBER: put_cur(K_INTEGER, E_NONE, 0);
        M_NUMDOT: close_int_dot();
        M_DECIMAL: put_cur(K_DOUBLE, E_NONE, 0);
        M_STRING: put_cur(K_ERROR, E_UNTERM_STR, 0);
        M_DIRECTIVE: close_directive();
        M_OP: close_single_op();
        default: ;
      endcase
      put_tok(K_EOF, E_NONE, 0, lx_line, lx_col, lx_off, 16'd0);
      lexer_reset();
      eof_count++;
    end else begin
      scan_byte(c);
      if (lx_off != OFF_SAT) lx_off++;
      if (c == "\n") begin
        if (lx_line != CNT_SAT) lx_line++;
        lx_col = 0;
      end else if (lx_col != CNT_SAT) begin
        lx_col++;
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
    foreach (step_toks[i]) board.note_token(step_toks[i]);
  endtask

  task automatic send_word(logic [7:0] c, logic eos);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid <= 1'b1;
    char_in.char_byte <= c;
    char_in.end_of_source <= eos;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    predict_word(c, eos);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic drain();
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random, mostly well-formed program text, some raw noise and end marks.
  task automatic send_random_piece();
    string frags[24] = '{"campaign ", "tactic(", "troop ", "ammo=", "codename",
      "status;", "brief ", "intel,", "evaluate ", "adjust{", "maintain}",
      "deploy ", "retreat\n", "abort ", "true", "false ", "#supply ", "#supplyx",
      "#junk ", "# note\n", "\"str x\"", "12.5 ", "7.", "a_b9 "};
    string ops[14] = '{"==", "!=", "<=", ">=", "&&", "||", "!", "=", "<", ">",
                       "&", "|", "+-*/%", "x.y"};
    int r;
    r = $urandom_range(99);
    if (r < 45) send_text(frags[$urandom_range(23)]);
    else if (r < 65) send_text(ops[$urandom_range(13)]);
    else if (r < 75) send_word(8'($urandom_range(9)) + "0", 1'b0);
    else if (r < 85) send_word(8'($urandom_range(255)), 1'b0);
    else if (r < 95) send_word(" ", 1'b0);
    else send_word(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    board = new();
    send_idle_pct = 17;
    recv_idle_pct = 54;
    items_sent = 0;
    eof_count = 0;
    lexer_reset();
    rst = 1'b1;
    char_in.valid = 1'b0;
    char_in.char_byte = 8'h00;
    char_in.end_of_source = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: keywords, long words, numbers with a trailing dot, ops,
    // directives, an empty hash line, bad bytes and an unterminated string.
    send_text("retreat abcdefghij 3.x#supply #bad\n&|>=");
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_text("#\n\"ab");
    send_word(8'h00, 1'b1);
    send_text("9.");
    send_word(8'hAA, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 17 : phase == 1 ? 54 : 0;
      recv_idle_pct = phase == 0 ? 54 : phase == 1 ? 17 : 0;
      repeat (20) send_random_piece();
      send_word(8'h00, 1'b1);
      drain();
    end
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Scanned %0d input words over %0d sources; %0d tokens checked.",
             items_sent, eof_count, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("[keyword_tokenizer_scanner] OK");
    else
      $display("[keyword_tokenizer_scanner] ERROR");
    $finish;
  end

  // Token sink with random back-pressure.
  initial begin
    token_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (token_out.valid && token_out.ready) begin
        exp_tok_t got;
        got.kind = token_out.token_kind;
        got.err = token_out.error_kind;
        got.bad = token_out.offending_char;
        got.line = token_out.start_line;
        got.col = token_out.start_column;
        got.off = token_out.start_offset;
        got.len = token_out.token_length;
        got.last = token_out.last_of_run;
        board.check_token(got);
      end
      token_out.ready <= !rst && !(recv_idle_pct > 0 &&
                                   $urandom_range(99) < recv_idle_pct);
    end
  end

endmodule
